/* hw/rtl/mfep_pkg.sv */
// Shared types and constants of the MIDI file event parser.
// No dependencies; every other file of the block uses this package.
package mfep_pkg;

  // Status byte values and masks.
  localparam logic [7:0] STATUS_BIT   = 8'h80;
  localparam logic [7:0] GROUP_MASK   = 8'hf0;
  localparam logic [7:0] SYSEX_START  = 8'hf0;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hf7;
  localparam logic [7:0] META_STATUS  = 8'hff;
  localparam logic [7:0] NOTE_OFF_VEL = 8'h40;
  localparam logic [3:0] OP_NOTE_OFF  = 4'h8;
  localparam logic [3:0] OP_NOTE_ON   = 4'h9;
  localparam logic [3:0] OP_PROGRAM   = 4'hc;
  localparam logic [3:0] OP_PRESSURE  = 4'hd;
  localparam logic [3:0] OP_SYSTEM    = 4'hf;

  localparam int unsigned COUNT_W = 28;
  localparam int unsigned SEEN_W  = 3;

  // Parser phase within one event.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DATA1,
    PH_DATA2,
    PH_METATYPE,
    PH_COUNT,
    PH_PAYLOAD
  } phase_t;

  // Kind of one result.
  typedef enum logic [2:0] {
    KIND_CHANNEL,
    KIND_SYSEX,
    KIND_META,
    KIND_PAYLOAD,
    KIND_ERROR
  } kind_t;

  // Error codes carried by an error result.
  typedef enum logic [1:0] {
    ERR_NO_RUNNING,
    ERR_UNSUPPORTED,
    ERR_COUNT_LONG,
    ERR_TRUNCATED
  } err_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [7:0]         running_status;
    phase_t             phase;
    logic [7:0]         current_status;
    logic [7:0]         held_first_data;
    logic [7:0]         held_meta_type;
    logic [COUNT_W-1:0] count_acc;
    logic [SEEN_W-1:0]  count_seen;
    logic [COUNT_W-1:0] payload_rem;
  } state_t;

  // One result item, with a flag telling whether the byte produced one.
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [3:0]         opcode;
    logic [3:0]         channel;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic [COUNT_W-1:0] payload_length;
    logic [7:0]         payload_byte;
    logic               is_terminator;
    logic               last;
    err_t               error_code;
  } result_t;

endpackage

/* hw/rtl/midi_file_event_parser.sv */
// Standard MIDI file track event parser, one byte per request.
// An accepted byte is held in the input register, and its result is then loaded into the result register.
// Throughput: one byte per cycle; the input register and result register each
// advance whenever the result register is empty or being taken.
// Reset (rst, synchronous): parser idle, no running status, both registers empty.
// Depends on mfep_pkg and mfep_step.
module midi_file_event_parser #(
  parameter int MAX_COUNT_BYTES = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   byte_in,
  input  logic                         end_of_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   kind,
  output logic [3:0]                   opcode,
  output logic [3:0]                   channel,
  output logic [7:0]                   first_data,
  output logic [7:0]                   second_data,
  output logic [mfep_pkg::COUNT_W-1:0] payload_length,
  output logic [7:0]                   payload_byte,
  output logic                         is_terminator,
  output logic                         last,
  output logic [1:0]                   error_code
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              hold_eod;
  logic              advance;
  mfep_pkg::state_t  state;
  mfep_pkg::state_t  state_next;
  mfep_pkg::result_t step_res;
  mfep_pkg::result_t result;

  // The held byte moves on when the result register can take its result.
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  mfep_step #(
    .MAX_COUNT_BYTES(MAX_COUNT_BYTES)
  ) u_step (
    .state      (state),
    .byte_in    (hold_byte),
    .end_of_data(hold_eod),
    .state_next (state_next),
    .result     (step_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_byte <= byte_in;
      hold_eod  <= end_of_data;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && step_res.valid) begin
      result <= step_res;
    end
  end

  assign kind           = result.kind;
  assign opcode         = result.opcode;
  assign channel        = result.channel;
  assign first_data     = result.first_data;
  assign second_data    = result.second_data;
  assign payload_length = result.payload_length;
  assign payload_byte   = result.payload_byte;
  assign is_terminator  = result.is_terminator;
  assign last           = result.last;
  assign error_code     = result.error_code;

  // An error result always closes the event.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mfep_pkg::KIND_ERROR |-> last)
    else $error("error result without last");

  // A terminator is only ever the final F7 payload byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |->
      kind == mfep_pkg::KIND_PAYLOAD && last && payload_byte == mfep_pkg::SYSEX_ESCAPE)
    else $error("terminator flag on a non-final or non-F7 byte");

  // The payload phase is never entered or held with nothing left to read.
  assert property (@(posedge clk) disable iff (rst)
    state.phase == mfep_pkg::PH_PAYLOAD |-> state.payload_rem != '0)
    else $error("payload phase with zero bytes remaining");

  // The count never runs past its byte limit.
  assert property (@(posedge clk) disable iff (rst)
    state.count_seen <= mfep_pkg::SEEN_W'(MAX_COUNT_BYTES))
    else $error("count byte counter beyond limit");

endmodule

/* hw/rtl/mfep_step.sv */
// Next-state and result logic of the parser for one track byte.
// Depends on mfep_pkg for the state, result, phase and code types.
module mfep_step #(
  parameter int MAX_COUNT_BYTES = 4
) (
  input  mfep_pkg::state_t  state,
  input  logic [7:0]        byte_in,
  input  logic              end_of_data,
  output mfep_pkg::state_t  state_next,
  output mfep_pkg::result_t result
);

  logic [7:0]                   status_sel;
  logic [3:0]                   op_sel;
  logic                         one_data;
  logic [mfep_pkg::COUNT_W-1:0] acc_next;
  logic [mfep_pkg::SEEN_W-1:0]  seen_next;
  logic [mfep_pkg::COUNT_W-1:0] rem_dec;
  logic                         fin;

  // Status used by a channel data byte: the running status in a running-status byte, else the current status.
  assign status_sel = (state.phase == mfep_pkg::PH_IDLE) ? state.running_status
                                                         : state.current_status;
  assign op_sel   = status_sel[7:4];
  assign one_data = (op_sel == mfep_pkg::OP_PROGRAM) || (op_sel == mfep_pkg::OP_PRESSURE);

  // Variable-length count and payload countdown.
  assign acc_next  = {state.count_acc[mfep_pkg::COUNT_W-8:0], byte_in[6:0]};
  assign seen_next = state.count_seen + mfep_pkg::SEEN_W'(1);
  assign rem_dec   = state.payload_rem - mfep_pkg::COUNT_W'(1);
  assign fin       = (rem_dec == '0);

  always_comb begin
    state_next = state;
    result     = '0;
    case (state.phase)
      mfep_pkg::PH_IDLE: begin
        if (byte_in[7]) begin
          state_next.current_status = byte_in;
          if ((byte_in & mfep_pkg::GROUP_MASK) != mfep_pkg::GROUP_MASK) begin
            // Channel status: sets running status.
            state_next.running_status = byte_in;
            state_next.phase          = mfep_pkg::PH_DATA1;
            if (end_of_data) begin
              result.valid      = 1'b1;
              result.kind       = mfep_pkg::KIND_ERROR;
              result.error_code = mfep_pkg::ERR_TRUNCATED;
            end
          end else begin
            // System status: clears running status and the count.
            state_next.running_status = '0;
            state_next.count_acc      = '0;
            state_next.count_seen     = '0;
            state_next.held_meta_type = '0;
            if (byte_in == mfep_pkg::SYSEX_START || byte_in == mfep_pkg::SYSEX_ESCAPE) begin
              state_next.phase = mfep_pkg::PH_COUNT;
            end else if (byte_in == mfep_pkg::META_STATUS) begin
              state_next.phase = mfep_pkg::PH_METATYPE;
            end else begin
              result.valid      = 1'b1;
              result.kind       = mfep_pkg::KIND_ERROR;
              result.error_code = mfep_pkg::ERR_UNSUPPORTED;
            end
            // An unsupported status has already reported its own error.
            if (end_of_data && !result.valid) begin
              result.valid      = 1'b1;
              result.kind       = mfep_pkg::KIND_ERROR;
              result.error_code = mfep_pkg::ERR_TRUNCATED;
            end
          end
        end else if (!state.running_status[7]) begin
          result.valid      = 1'b1;
          result.kind       = mfep_pkg::KIND_ERROR;
          result.error_code = mfep_pkg::ERR_NO_RUNNING;
        end else begin
          state_next.current_status = state.running_status;
          if (one_data) begin
            result.valid      = 1'b1;
            result.kind       = mfep_pkg::KIND_CHANNEL;
            result.opcode     = op_sel;
            result.channel    = status_sel[3:0];
            result.first_data = byte_in;
          end else begin
            state_next.held_first_data = byte_in;
            state_next.phase           = mfep_pkg::PH_DATA2;
            if (end_of_data) begin
              result.valid      = 1'b1;
              result.kind       = mfep_pkg::KIND_ERROR;
              result.error_code = mfep_pkg::ERR_TRUNCATED;
            end
          end
        end
      end
      mfep_pkg::PH_DATA1: begin
        if (one_data) begin
          result.valid      = 1'b1;
          result.kind       = mfep_pkg::KIND_CHANNEL;
          result.opcode     = op_sel;
          result.channel    = status_sel[3:0];
          result.first_data = byte_in;
        end else begin
          state_next.held_first_data = byte_in;
          state_next.phase           = mfep_pkg::PH_DATA2;
          if (end_of_data) begin
            result.valid      = 1'b1;
            result.kind       = mfep_pkg::KIND_ERROR;
            result.error_code = mfep_pkg::ERR_TRUNCATED;
          end
        end
      end
      mfep_pkg::PH_DATA2: begin
        // Two-byte message complete; a silent note-on reads as note-off.
        result.valid       = 1'b1;
        result.kind        = mfep_pkg::KIND_CHANNEL;
        result.channel     = status_sel[3:0];
        result.first_data  = state.held_first_data;
        if (op_sel == mfep_pkg::OP_NOTE_ON && byte_in == '0) begin
          result.opcode      = mfep_pkg::OP_NOTE_OFF;
          result.second_data = mfep_pkg::NOTE_OFF_VEL;
        end else begin
          result.opcode      = op_sel;
          result.second_data = byte_in;
        end
      end
      mfep_pkg::PH_METATYPE: begin
        state_next.held_meta_type = byte_in;
        state_next.phase          = mfep_pkg::PH_COUNT;
        if (end_of_data) begin
          result.valid      = 1'b1;
          result.kind       = mfep_pkg::KIND_ERROR;
          result.error_code = mfep_pkg::ERR_TRUNCATED;
        end
      end
      mfep_pkg::PH_COUNT: begin
        state_next.count_acc  = acc_next;
        state_next.count_seen = seen_next;
        if (byte_in[7]) begin
          if (seen_next >= mfep_pkg::SEEN_W'(MAX_COUNT_BYTES)) begin
            result.valid      = 1'b1;
            result.kind       = mfep_pkg::KIND_ERROR;
            result.error_code = mfep_pkg::ERR_COUNT_LONG;
          end else if (end_of_data) begin
            result.valid      = 1'b1;
            result.kind       = mfep_pkg::KIND_ERROR;
            result.error_code = mfep_pkg::ERR_TRUNCATED;
          end
        end else begin
          state_next.payload_rem = acc_next;
          if (end_of_data && acc_next != '0) begin
            result.valid      = 1'b1;
            result.kind       = mfep_pkg::KIND_ERROR;
            result.error_code = mfep_pkg::ERR_TRUNCATED;
          end else begin
            // Header result; a zero-length payload ends the event here.
            result.valid          = 1'b1;
            result.kind           = (state.current_status == mfep_pkg::META_STATUS) ?
                                    mfep_pkg::KIND_META : mfep_pkg::KIND_SYSEX;
            result.opcode         = mfep_pkg::OP_SYSTEM;
            result.channel        = state.current_status[3:0];
            result.first_data     = (state.current_status == mfep_pkg::META_STATUS) ?
                                    state.held_meta_type : '0;
            result.payload_length = acc_next;
            result.last           = (acc_next == '0);
            state_next.phase      = (acc_next == '0) ? mfep_pkg::PH_IDLE
                                                     : mfep_pkg::PH_PAYLOAD;
          end
        end
      end
      mfep_pkg::PH_PAYLOAD: begin
        state_next.payload_rem = rem_dec;
        if (end_of_data && !fin) begin
          result.valid      = 1'b1;
          result.kind       = mfep_pkg::KIND_ERROR;
          result.error_code = mfep_pkg::ERR_TRUNCATED;
        end else begin
          result.valid         = 1'b1;
          result.kind          = mfep_pkg::KIND_PAYLOAD;
          result.payload_byte  = byte_in;
          result.is_terminator = fin && (state.current_status != mfep_pkg::META_STATUS) &&
                                 (byte_in == mfep_pkg::SYSEX_ESCAPE);
          result.last          = fin;
          if (fin) begin
            state_next.phase = mfep_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        state_next.phase = mfep_pkg::PH_IDLE;
      end
    endcase

    // Channel events and errors both close the event and return the parser to idle.
    if (result.valid && (result.kind == mfep_pkg::KIND_CHANNEL ||
                         result.kind == mfep_pkg::KIND_ERROR)) begin
      state_next.phase = mfep_pkg::PH_IDLE;
      result.last      = 1'b1;
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for midi_file_event_parser: byte stream in, parsed events out.
// Depends on mfep_pkg and the parser RTL; a scoreboard class predicts every result.
module testbench;

  localparam int MAX_COUNT_BYTES = 4;
  localparam int RANDOM_BYTES    = 400;
  localparam int HOLD_CYCLES     = 60;
  localparam int TIMEOUT         = 3_000_000;

  // One parsed result, field for field as the block presents it.
  typedef struct packed {
    mfep_pkg::kind_t              kind;
    logic [3:0]                   opcode;
    logic [3:0]                   channel;
    logic [7:0]                   first_data;
    logic [7:0]                   second_data;
    logic [mfep_pkg::COUNT_W-1:0] payload_length;
    logic [7:0]                   payload_byte;
    logic                         is_terminator;
    logic                         last;
    mfep_pkg::err_t               error_code;
  } event_result_t;

  // Tracks parser state for each accepted byte and checks the results that come out.
  class smf_event_scoreboard;
    event_result_t                parsed_q[$];
    int                           failures;
    int                           results_seen;
    int                           error_results;
    int                           payload_results;
    int                           count_limit;
    logic [7:0]                   last_channel_status;
    logic [7:0]                   event_status;
    logic [7:0]                   first_byte_hold;
    logic [7:0]                   meta_type_hold;
    mfep_pkg::phase_t             step_phase;
    logic [mfep_pkg::COUNT_W-1:0] length_acc;
    logic [mfep_pkg::COUNT_W-1:0] bytes_left;
    logic [mfep_pkg::SEEN_W-1:0]  length_bytes;

    function new(int limit);
      count_limit = limit;
      failures = 0;
      results_seen = 0;
      error_results = 0;
      payload_results = 0;
      last_channel_status = '0;
      event_status = '0;
      first_byte_hold = '0;
      meta_type_hold = '0;
      step_phase = mfep_pkg::PH_IDLE;
      length_acc = '0;
      bytes_left = '0;
      length_bytes = '0;
    endfunction

    function bit has_running();
      return last_channel_status[7];
    endfunction

    function int outstanding();
      return parsed_q.size();
    endfunction

    function string show(event_result_t r);
      return $sformatf("kind=%0d op=%h ch=%h d1=%h d2=%h len=%h pb=%h term=%b last=%b err=%0d",
                       r.kind, r.opcode, r.channel, r.first_data, r.second_data,
                       r.payload_length, r.payload_byte, r.is_terminator, r.last,
                       r.error_code);
    endfunction

    // An error ends the current event and sends the parser back to idle.
    function event_result_t error_item(mfep_pkg::err_t code);
      event_result_t r;
      r = '0;
      r.kind = mfep_pkg::KIND_ERROR;
      r.last = 1'b1;
      r.error_code = code;
      step_phase = mfep_pkg::PH_IDLE;
      return r;
    endfunction

    // A complete channel message; note-on with zero velocity turns into note-off.
    function event_result_t channel_item(logic [7:0] d1, logic [7:0] d2, bit two);
      event_result_t r;
      r = '0;
      r.kind = mfep_pkg::KIND_CHANNEL;
      r.opcode = event_status[7:4];
      r.channel = event_status[3:0];
      r.first_data = d1;
      r.second_data = two ? d2 : 8'h00;
      if (two && r.opcode == mfep_pkg::OP_NOTE_ON && d2 == 8'h00) begin
        r.opcode = mfep_pkg::OP_NOTE_OFF;
        r.second_data = mfep_pkg::NOTE_OFF_VEL;
      end
      r.last = 1'b1;
      step_phase = mfep_pkg::PH_IDLE;
      return r;
    endfunction

    // First data byte of a channel message whose status is already known.
    function bit first_data_byte(logic [7:0] b, logic eod, output event_result_t r);
      r = '0;
      if (event_status[7:4] == mfep_pkg::OP_PROGRAM ||
          event_status[7:4] == mfep_pkg::OP_PRESSURE) begin
        r = channel_item(b, 8'h00, 1'b0);
        return 1'b1;
      end
      first_byte_hold = b;
      step_phase = mfep_pkg::PH_DATA2;
      if (eod) begin
        r = error_item(mfep_pkg::ERR_TRUNCATED);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Advances the parser by one accepted byte and queues the result it causes.
    function void parse_byte(logic [7:0] b, logic eod);
      event_result_t r;
      bit made;
      r = '0;
      made = 1'b0;
      case (step_phase)
        mfep_pkg::PH_IDLE: begin
          if (b[7]) begin
            event_status = b;
            if ((b & mfep_pkg::GROUP_MASK) != mfep_pkg::GROUP_MASK) begin
              last_channel_status = b;
              step_phase = mfep_pkg::PH_DATA1;
            end else begin
              last_channel_status = '0;
              length_acc = '0;
              length_bytes = '0;
              meta_type_hold = '0;
              if (b == mfep_pkg::SYSEX_START || b == mfep_pkg::SYSEX_ESCAPE) begin
                step_phase = mfep_pkg::PH_COUNT;
              end else if (b == mfep_pkg::META_STATUS) begin
                step_phase = mfep_pkg::PH_METATYPE;
              end else begin
                r = error_item(mfep_pkg::ERR_UNSUPPORTED);
                made = 1'b1;
              end
            end
            if (!made && eod) begin
              r = error_item(mfep_pkg::ERR_TRUNCATED);
              made = 1'b1;
            end
          end else if (!last_channel_status[7]) begin
            r = error_item(mfep_pkg::ERR_NO_RUNNING);
            made = 1'b1;
          end else begin
            event_status = last_channel_status;
            made = first_data_byte(b, eod, r);
          end
        end
        mfep_pkg::PH_DATA1: made = first_data_byte(b, eod, r);
        mfep_pkg::PH_DATA2: begin
          r = channel_item(first_byte_hold, b, 1'b1);
          made = 1'b1;
        end
        mfep_pkg::PH_METATYPE: begin
          meta_type_hold = b;
          step_phase = mfep_pkg::PH_COUNT;
          if (eod) begin
            r = error_item(mfep_pkg::ERR_TRUNCATED);
            made = 1'b1;
          end
        end
        mfep_pkg::PH_COUNT: begin
          length_acc = {length_acc[mfep_pkg::COUNT_W-8:0], b[6:0]};
          length_bytes = length_bytes + 1'b1;
          if (b[7]) begin
            if (length_bytes >= count_limit) begin
              r = error_item(mfep_pkg::ERR_COUNT_LONG);
              made = 1'b1;
            end else if (eod) begin
              r = error_item(mfep_pkg::ERR_TRUNCATED);
              made = 1'b1;
            end
          end else begin
            bytes_left = length_acc;
            if (eod && bytes_left != 0) begin
              r = error_item(mfep_pkg::ERR_TRUNCATED);
            end else begin
              r.kind = (event_status == mfep_pkg::META_STATUS) ? mfep_pkg::KIND_META
                                                               : mfep_pkg::KIND_SYSEX;
              r.opcode = mfep_pkg::OP_SYSTEM;
              r.channel = event_status[3:0];
              r.first_data = (event_status == mfep_pkg::META_STATUS) ? meta_type_hold : 8'h00;
              r.payload_length = length_acc;
              r.last = (bytes_left == 0);
              step_phase = (bytes_left == 0) ? mfep_pkg::PH_IDLE : mfep_pkg::PH_PAYLOAD;
            end
            made = 1'b1;
          end
        end
        mfep_pkg::PH_PAYLOAD: begin
          bytes_left = bytes_left - 1'b1;
          if (eod && bytes_left != 0) begin
            r = error_item(mfep_pkg::ERR_TRUNCATED);
          end else begin
            r.kind = mfep_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.is_terminator = (bytes_left == 0 && event_status != mfep_pkg::META_STATUS &&
                               b == mfep_pkg::SYSEX_ESCAPE);
            r.last = (bytes_left == 0);
            if (bytes_left == 0) step_phase = mfep_pkg::PH_IDLE;
          end
          made = 1'b1;
        end
        default: step_phase = mfep_pkg::PH_IDLE;
      endcase
      if (made) parsed_q.push_back(r);
    endfunction

    // Compares one result from the block with the oldest predicted one.
    function void compare_result(event_result_t seen);
      event_result_t want;
      string bad;
      results_seen++;
      if (seen.kind == mfep_pkg::KIND_ERROR) error_results++;
      if (seen.kind == mfep_pkg::KIND_PAYLOAD) payload_results++;
      if (parsed_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result %0d: %s", results_seen, show(seen));
        return;
      end
      want = parsed_q.pop_front();
      bad = "";
      if (seen.kind !== want.kind) bad = {bad, " kind"};
      if (seen.opcode !== want.opcode) bad = {bad, " opcode"};
      if (seen.channel !== want.channel) bad = {bad, " channel"};
      if (seen.first_data !== want.first_data) bad = {bad, " first_data"};
      if (seen.second_data !== want.second_data) bad = {bad, " second_data"};
      if (seen.payload_length !== want.payload_length) bad = {bad, " payload_length"};
      if (seen.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
      if (seen.is_terminator !== want.is_terminator) bad = {bad, " is_terminator"};
      if (seen.last !== want.last) bad = {bad, " last"};
      if (seen.error_code !== want.error_code) bad = {bad, " error_code"};
      if (bad != "") begin
        failures++;
        if (failures <= 10) begin
          $display("result %0d differs in%s", results_seen, bad);
          $display("  expected %s", show(want));
          $display("  got      %s", show(seen));
        end
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   byte_in = 8'h00;
  logic                         end_of_data = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [2:0]                   kind;
  logic [3:0]                   opcode;
  logic [3:0]                   channel;
  logic [7:0]                   first_data;
  logic [7:0]                   second_data;
  logic [mfep_pkg::COUNT_W-1:0] payload_length;
  logic [7:0]                   payload_byte;
  logic                         is_terminator;
  logic                         last;
  logic [1:0]                   error_code;

  smf_event_scoreboard sb;
  int bytes_sent = 0;
  int trunc_pct = 2;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  bit hold_out = 1'b0;

  midi_file_event_parser #(.MAX_COUNT_BYTES(MAX_COUNT_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_in(byte_in),
    .end_of_data(end_of_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .opcode(opcode),
    .channel(channel),
    .first_data(first_data),
    .second_data(second_data),
    .payload_length(payload_length),
    .payload_byte(payload_byte),
    .is_terminator(is_terminator),
    .last(last),
    .error_code(error_code)
  );

  always #5 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic trunc_roll();
    return $urandom_range(99) < trunc_pct;
  endfunction

  // Data bytes are mostly proper 7-bit values, sometimes with the top bit set.
  function automatic logic [7:0] data_roll();
    if ($urandom_range(99) < 85) return 8'($urandom_range(127));
    return 8'($urandom_range(255));
  endfunction

  // Offers one byte, waits for the handshake, then idles for a random gap.
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    in_valid <= 1'b1;
    byte_in <= b;
    end_of_data <= eod;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.parse_byte(b, eod);
    bytes_sent++;
    gap = pick_gap(steady_in);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      byte_in <= 8'($urandom_range(255));
      end_of_data <= 1'($urandom_range(1));
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Channel message, with or without an explicit status byte.
  task automatic send_channel_msg();
    logic [3:0] op;
    logic [7:0] d1;
    logic [7:0] d2;
    op = 4'(4'h8 + $urandom_range(6));
    if (!sb.has_running() || $urandom_range(99) < 70) begin
      send_byte({op, 4'($urandom_range(15))}, trunc_roll());
    end else begin
      op = sb.last_channel_status[7:4];
    end
    d1 = data_roll();
    d2 = data_roll();
    if (op == mfep_pkg::OP_NOTE_ON && $urandom_range(3) == 0) d2 = 8'h00;
    send_byte(d1, trunc_roll());
    if (op != mfep_pkg::OP_PROGRAM && op != mfep_pkg::OP_PRESSURE) send_byte(d2, trunc_roll());
  endtask

  // Sysex or meta event with a variable-length count, sometimes zero-padded.
  task automatic send_long_event();
    logic [7:0] status;
    int roll;
    int len;
    int groups;
    int pad;
    roll = $urandom_range(2);
    status = (roll == 0) ? mfep_pkg::SYSEX_START :
             (roll == 1) ? mfep_pkg::SYSEX_ESCAPE : mfep_pkg::META_STATUS;
    send_byte(status, trunc_roll());
    if (status == mfep_pkg::META_STATUS) send_byte(8'($urandom_range(255)), trunc_roll());
    roll = $urandom_range(99);
    len = (roll < 80) ? $urandom_range(5) :
          (roll < 96) ? $urandom_range(20, 6) : $urandom_range(140, 128);
    groups = (len >= 128) ? 2 : 1;
    pad = ($urandom_range(99) < 25) ? $urandom_range(4 - groups) : 0;
    repeat (pad) send_byte(mfep_pkg::STATUS_BIT, trunc_roll());
    if (groups == 2) send_byte(mfep_pkg::STATUS_BIT | 8'(len >> 7), trunc_roll());
    send_byte(8'(len & 127), trunc_roll());
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && status != mfep_pkg::META_STATUS && $urandom_range(1) == 1) begin
        send_byte(mfep_pkg::SYSEX_ESCAPE, trunc_roll());
      end else begin
        send_byte(8'($urandom_range(255)), trunc_roll());
      end
    end
  endtask

  // Checks every result the block hands over.
  always @(posedge clk) begin : watch_results
    event_result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.kind = mfep_pkg::kind_t'(kind);
      seen.opcode = opcode;
      seen.channel = channel;
      seen.first_data = first_data;
      seen.second_data = second_data;
      seen.payload_length = payload_length;
      seen.payload_byte = payload_byte;
      seen.is_terminator = is_terminator;
      seen.last = last;
      seen.error_code = mfep_pkg::err_t'(error_code);
      sb.compare_result(seen);
    end
  end

  // Result side: random stalls, steady stretches, and one long hold-off on request.
  initial begin : result_taker
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99) < 3) steady_out = !steady_out;
        stall_left = pick_gap(steady_out);
      end
    end
  end

  // Stimulus: reset, directed cases, then random event streams.
  initial begin : stimulus
    int directed_sent;
    int roll;
    bit hold_started;
    bit drained;
    logic [7:0] b;
    hold_started = 1'b0;
    drained = 1'b0;
    sb = new(MAX_COUNT_BYTES);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Data byte before any running status.
    send_byte(8'h40, 1'b0);
    // Note-on with zero velocity, then more notes on running status.
    send_byte(8'h93, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'h7f, 1'b0);
    // Program change on channel 15 with a data byte that has its top bit set.
    send_byte(8'hcf, 1'b0);
    send_byte(8'hff, 1'b0);
    // Unsupported system status clears running status.
    send_byte(8'hf3, 1'b0);
    // Sysex ending in the escape byte, which is flagged as the terminator.
    send_byte(mfep_pkg::SYSEX_START, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(mfep_pkg::SYSEX_ESCAPE, 1'b0);
    // Meta event with an empty payload: the header is the last result.
    send_byte(mfep_pkg::META_STATUS, 1'b0);
    send_byte(8'h2f, 1'b0);
    send_byte(8'h00, 1'b0);
    // Count that runs past the allowed number of bytes.
    send_byte(mfep_pkg::SYSEX_ESCAPE, 1'b0);
    repeat (4) send_byte(mfep_pkg::STATUS_BIT, 1'b0);
    // Pitch bend cut short by the end of the buffer.
    send_byte(8'he5, 1'b0);
    send_byte(8'h00, 1'b1);
    // Largest possible count, then the buffer ends inside the payload.
    send_byte(mfep_pkg::META_STATUS, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (3) send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b1);
    // An unsupported status at the end of the buffer still reports itself.
    send_byte(8'hf4, 1'b1);
    directed_sent = bytes_sent;

    // Mostly well-formed events, with some noise and truncated ones mixed in.
    while (bytes_sent < directed_sent + RANDOM_BYTES) begin
      if (!hold_started && bytes_sent > directed_sent + 150) begin
        hold_started = 1'b1;
        steady_in = 1'b1;
        hold_out = 1'b1;
      end
      if (!drained && bytes_sent > directed_sent + 300) begin
        drained = 1'b1;
        drain_results();
      end
      if (!hold_out && $urandom_range(99) < 8) steady_in = !steady_in;
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_channel_msg();
      end else if (roll < 80) begin
        send_long_event();
      end else begin
        case ($urandom_range(3))
          0: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
          1: begin
            b = 8'(8'hf1 + $urandom_range(12));
            if (b >= mfep_pkg::SYSEX_ESCAPE) b = b + 8'h01;
            send_byte(b, 1'($urandom_range(1)));
          end
          2: begin
            send_byte(mfep_pkg::SYSEX_START, 1'b0);
            repeat ($urandom_range(5, 4)) send_byte(mfep_pkg::STATUS_BIT | data_roll(), 1'b0);
          end
          default: begin
            trunc_pct = 35;
            if ($urandom_range(1) == 0) send_channel_msg();
            else send_long_event();
            trunc_pct = 2;
          end
        endcase
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    $display("Sent %0d track bytes; checked %0d results (%0d payload bytes, %0d errors).",
             bytes_sent, sb.results_seen, sb.payload_results, sb.error_results);
    $display("Stream mixed channel, sysex and meta events with truncation and bad input.");
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", sb.failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #TIMEOUT;
    $display("timeout with %0d results outstanding", sb.outstanding());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
